### rtl/websocket_frame_deframer_assert.svh
// assertion macros shared by the checker
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define WSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wsd check failed");

// next-cycle implication, sampled on the rising clock edge
`define WSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wsd check failed");

`endif

### rtl/wsd_pkg.sv
package wsd_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_CLOSE   = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  // frame opcodes of interest
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpBin   = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;

  // 7-bit length codes that select an extended length
  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  // extended length byte counts, minus one
  localparam logic [2:0] Ext16Last = 3'd1;
  localparam logic [2:0] Ext64Last = 3'd7;

  // depth of the queue between parser and output stage
  localparam int unsigned QueueDepth = 2;

  // one result item as handed from parser to output stage
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  raw;
    logic [7:0]  key;
    logic [3:0]  opcode;
    logic        last;
  } cmd_t;

endpackage

### rtl/wsd_front.sv
module wsd_front import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       space_i,
  output logic       rx_ready_o,
  output logic       push_o,
  output cmd_t       cmd_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  ext_idx_q, ext_idx_d;
  logic [3:0]  opcode_q, opcode_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  pos_q, pos_d;
  logic        halted_q, halted_d;

  logic        accept;
  logic        is_data_op;
  logic [7:0]  key_byte;
  logic        fin;

  assign rx_ready_o = space_i;
  assign accept     = rx_valid_i && space_i;
  assign is_data_op = (opcode_q == OpText) || (opcode_q == OpBin);
  assign fin        = (rem_q == 64'd1);

  // key byte for the current payload position, first key byte on top
  always_comb begin
    case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // header parser and payload classifier
  always_comb begin
    phase_d   = phase_q;
    ext_idx_d = ext_idx_q;
    opcode_d  = opcode_q;
    rem_d     = rem_q;
    key_d     = key_q;
    pos_d     = pos_q;
    halted_d  = halted_q;
    push_o    = 1'b0;
    cmd_o     = '{kind: KIND_PAYLOAD, raw: 8'd0, key: 8'd0, opcode: opcode_q, last: 1'b1};

    if (accept && !halted_q) begin
      unique case (phase_q)
        PH_HDR1: begin
          if (!rx_byte_i[7]) begin
            halted_d   = 1'b1;
            push_o     = 1'b1;
            cmd_o.kind = KIND_ERROR;
          end else begin
            pos_d = 2'd0;
            if (rx_byte_i[6:0] == Len16Code) begin
              rem_d     = '0;
              ext_idx_d = Ext16Last;
              phase_d   = PH_EXT;
            end else if (rx_byte_i[6:0] == Len64Code) begin
              rem_d     = '0;
              ext_idx_d = Ext64Last;
              phase_d   = PH_EXT;
            end else begin
              rem_d   = {57'd0, rx_byte_i[6:0]};
              phase_d = PH_MASK;
            end
          end
        end
        PH_EXT: begin
          rem_d = {rem_q[55:0], rx_byte_i};
          if (ext_idx_q == 3'd0) begin
            phase_d = PH_MASK;
          end else begin
            ext_idx_d = ext_idx_q - 3'd1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[23:0], rx_byte_i};
          pos_d = pos_q + 2'd1;
          if (pos_q == 2'd3) begin
            phase_d = PH_DATA;
            // empty payload ends the frame on the last key byte
            if (rem_q == 64'd0) begin
              phase_d   = PH_HDR0;
              pos_d     = 2'd0;
              ext_idx_d = 3'd0;
              if (opcode_q == OpClose) begin
                push_o     = 1'b1;
                cmd_o.kind = KIND_CLOSE;
              end else if (is_data_op) begin
                push_o     = 1'b1;
                cmd_o.kind = KIND_EMPTY;
              end
            end
          end
        end
        PH_DATA: begin
          rem_d = rem_q - 64'd1;
          pos_d = pos_q + 2'd1;
          if (is_data_op) begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_PAYLOAD;
            cmd_o.raw  = rx_byte_i;
            cmd_o.key  = key_byte;
            cmd_o.last = fin;
          end else if (fin && (opcode_q == OpClose)) begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_CLOSE;
          end
          if (fin) begin
            phase_d   = PH_HDR0;
            pos_d     = 2'd0;
            ext_idx_d = 3'd0;
          end
        end
        default: begin
          // first header byte
          opcode_d = rx_byte_i[3:0];
          phase_d  = PH_HDR1;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      ext_idx_q <= 3'd0;
      opcode_q  <= 4'd0;
      rem_q     <= 64'd0;
      pos_q     <= 2'd0;
      halted_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      ext_idx_q <= ext_idx_d;
      opcode_q  <= opcode_d;
      rem_q     <= rem_d;
      pos_q     <= pos_d;
      halted_q  <= halted_d;
    end
  end

  // masking key
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

### rtl/wsd_fifo.sv
module wsd_fifo import wsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic space_o,
  input  logic pop_i,
  output logic avail_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign space_o = (cnt_q != CntW'(QueueDepth));
  assign avail_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && space_o;
  assign do_pop  = pop_i && avail_o;

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

### rtl/wsd_back.sv
module wsd_back import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       avail_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       tx_valid_o,
  input  logic       tx_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [3:0] frame_opcode_o,
  output logic       last_o
);

  logic       valid_q, valid_d;
  kind_e      kind_q;
  logic [7:0] data_q;
  logic [3:0] opcode_q;
  logic       last_q;

  // load a new item when the output register is empty or being drained
  assign pop_o   = avail_i && (!valid_q || tx_ready_i);
  assign valid_d = pop_o || (valid_q && !tx_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // unmask and hold the result
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= cmd_i.kind;
      data_q   <= cmd_i.raw ^ cmd_i.key;
      opcode_q <= cmd_i.opcode;
      last_q   <= cmd_i.last;
    end
  end

  assign tx_valid_o     = valid_q;
  assign kind_o         = kind_q;
  assign data_byte_o    = data_q;
  assign frame_opcode_o = opcode_q;
  assign last_o         = last_q;

endmodule

### rtl/websocket_frame_deframer.sv
// Client-to-server WebSocket deframer: takes one received byte per cycle, back to back,
// while its queue has space, parses the header (opcode, mask bit, 7/16/64-bit length,
// 4-byte masking key) and returns unmasked text and binary payload bytes as they arrive,
// with last set on the final byte of each frame. Empty text/binary frames give one
// empty-frame item, close frames give one close item after their payload, other opcodes
// give nothing, and an unmasked frame gives an error item after which input is taken and
// dropped until reset. Throughput is one byte per cycle while the queue has space; the
// parser steps the 64-bit remaining-length counter once per byte. A result is written to
// the queue as its byte is taken, then loaded into the output register once that is empty
// or being drained; a two-entry queue keeps input flowing while the output stalls briefly.
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       tx_valid_o,
  input  logic       tx_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [3:0] frame_opcode_o,
  output logic       last_o
);

  logic space;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic avail;
  cmd_t head_cmd;

  // header parser
  wsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_byte_i  (rx_byte_i),
    .space_i    (space),
    .rx_ready_o (rx_ready_o),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // queue between parser and output stage
  wsd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .space_o (space),
    .pop_i   (pop),
    .avail_o (avail),
    .cmd_o   (head_cmd)
  );

  // unmasking and output register
  wsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .avail_i        (avail),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .tx_valid_o     (tx_valid_o),
    .tx_ready_i     (tx_ready_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .frame_opcode_o (frame_opcode_o),
    .last_o         (last_o)
  );

endmodule

### rtl/wsd_checker.sv
`include "websocket_frame_deframer_assert.svh"

module wsd_checker import wsd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       tx_valid_o,
  input logic       tx_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] data_byte_o,
  input logic [3:0] frame_opcode_o,
  input logic       last_o
);

  // a stalled result stays offered
  `WSD_ASSERT_NEXT(a_tx_hold, tx_valid_o && !tx_ready_i, tx_valid_o)

  // only payload items carry data
  `WSD_ASSERT_NOW(a_data_zero, tx_valid_o && (kind_o != KIND_PAYLOAD), data_byte_o == 8'd0)

  // status items always close their frame
  `WSD_ASSERT_NOW(a_status_last, tx_valid_o && (kind_o != KIND_PAYLOAD), last_o)

  // payload only comes from text or binary frames
  `WSD_ASSERT_NOW(a_payload_op, tx_valid_o && (kind_o == KIND_PAYLOAD), (frame_opcode_o == OpText) || (frame_opcode_o == OpBin))

  // nothing follows an error item
  `WSD_ASSERT_NEXT(a_error_final, tx_valid_o && tx_ready_i && (kind_o == KIND_ERROR), !tx_valid_o)

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import wsd_pkg::*;

  localparam int unsigned RandomBytes = 1350;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned TailCycles  = 10;

  // how the payload length is coded in the header
  typedef enum int {LenShort, LenExt16, LenExt64} len_form_e;

  // one deframed result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
  } deframed_t;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       rx_valid_i = 1'b0;
  logic [7:0] rx_byte_i  = 8'h00;
  logic       tx_ready_i = 1'b0;
  logic       rx_ready_o;
  logic       tx_valid_o;
  logic [1:0] kind_o;
  logic [7:0] data_byte_o;
  logic [3:0] frame_opcode_o;
  logic       last_o;

  logic [7:0] rx_stream_q[$];
  deframed_t  deframed_q[$];
  deframed_t  want;

  int unsigned total_items  = 1;
  int unsigned bytes_taken  = 0;
  int unsigned idle_stage;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count   = 0;
  logic        hold_done    = 1'b0;
  logic        draining     = 1'b0;

  // parser state of the predictor
  phase_e      prd_phase     = PH_HDR0;
  logic [2:0]  prd_ext_left  = 3'd0;
  logic [3:0]  prd_opcode    = 4'd0;
  logic [63:0] prd_remaining = 64'd0;
  logic [31:0] prd_key       = 32'd0;
  logic [1:0]  prd_key_pos   = 2'd0;
  logic        prd_halted    = 1'b0;

  assign idle_stage = bytes_taken * 3 / total_items;

  websocket_frame_deframer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .tx_valid_o     (tx_valid_o),
    .tx_ready_i     (tx_ready_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .frame_opcode_o (frame_opcode_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  // append one byte to the stream to be sent
  function automatic void stream_byte(logic [7:0] b);
    rx_stream_q.insert(rx_stream_q.size(), b);
  endfunction

  function automatic void push_result(kind_e k, logic [7:0] d, logic [3:0] op, logic l);
    deframed_t r;
    r.kind   = k;
    r.data   = d;
    r.opcode = op;
    r.last   = l;
    deframed_q.insert(deframed_q.size(), r);
  endfunction

  function automatic logic is_data_op(logic [3:0] op);
    return (op == OpText) || (op == OpBin);
  endfunction

  // back to the header, close frames also drop all parser state
  function automatic void end_of_frame(logic report_empty);
    prd_phase    = PH_HDR0;
    prd_key_pos  = 2'd0;
    prd_ext_left = 3'd0;
    if (prd_opcode == OpClose) begin
      push_result(KIND_CLOSE, 8'h00, prd_opcode, 1'b1);
      prd_opcode    = 4'd0;
      prd_remaining = 64'd0;
      prd_key       = 32'd0;
      prd_halted    = 1'b0;
    end else if (report_empty) begin
      push_result(KIND_EMPTY, 8'h00, prd_opcode, 1'b1);
    end
  endfunction

  // advance the predicted parser by one received byte
  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] plain;
    logic [3:0] op;
    if (prd_halted) return;
    case (prd_phase)
      PH_HDR1: begin
        if (!b[7]) begin
          prd_halted = 1'b1;
          push_result(KIND_ERROR, 8'h00, prd_opcode, 1'b1);
        end else begin
          prd_key_pos = 2'd0;
          if (b[6:0] == Len16Code) begin
            prd_remaining = 64'd0;
            prd_ext_left  = Ext16Last;
            prd_phase     = PH_EXT;
          end else if (b[6:0] == Len64Code) begin
            prd_remaining = 64'd0;
            prd_ext_left  = Ext64Last;
            prd_phase     = PH_EXT;
          end else begin
            prd_remaining = 64'(b[6:0]);
            prd_phase     = PH_MASK;
          end
        end
      end
      PH_EXT: begin
        prd_remaining = {prd_remaining[55:0], b};
        if (prd_ext_left == 3'd0) prd_phase = PH_MASK;
        else prd_ext_left = prd_ext_left - 3'd1;
      end
      PH_MASK: begin
        prd_key     = {prd_key[23:0], b};
        prd_key_pos = prd_key_pos + 2'd1;
        if (prd_key_pos == 2'd0) begin
          prd_phase = PH_DATA;
          if (prd_remaining == 64'd0) end_of_frame(is_data_op(prd_opcode));
        end
      end
      PH_DATA: begin
        plain         = b ^ 8'(prd_key >> (8 * (3 - int'(prd_key_pos))));
        prd_key_pos   = prd_key_pos + 2'd1;
        prd_remaining = prd_remaining - 64'd1;
        op            = prd_opcode;
        if (is_data_op(op)) begin
          if (prd_remaining == 64'd0) end_of_frame(1'b0);
          push_result(KIND_PAYLOAD, plain, op, prd_remaining == 64'd0);
        end else if (prd_remaining == 64'd0) begin
          end_of_frame(1'b0);
        end
      end
      default: begin
        prd_opcode = b[3:0];
        prd_phase  = PH_HDR1;
      end
    endcase
  endfunction

  // one masked frame with random payload
  task automatic queue_frame(input logic [3:0] op, input logic [3:0] flags,
                             input int unsigned len, input len_form_e form,
                             input logic [31:0] key);
    logic [63:0] len64;
    len64 = 64'(len);
    stream_byte({flags, op});
    case (form)
      LenExt16: begin
        stream_byte({1'b1, Len16Code});
        stream_byte(len64[15:8]);
        stream_byte(len64[7:0]);
      end
      LenExt64: begin
        stream_byte({1'b1, Len64Code});
        for (int i = 7; i >= 0; i--) stream_byte(8'(len64 >> (8 * i)));
      end
      default: stream_byte({1'b1, len64[6:0]});
    endcase
    for (int k = 0; k < 4; k++) stream_byte(key[31 - 8 * k -: 8]);
    for (int unsigned i = 0; i < len; i++) stream_byte(8'($urandom_range(255)));
  endtask

  // stimulus, reset and end of run
  initial begin
    int unsigned pick;
    int unsigned len;
    logic [3:0]  op;
    len_form_e   form;

    // directed: one byte text, empty binary with all flag bits, empty close, ping
    queue_frame(OpText, 4'h8, 1, LenShort, 32'hFFFF_FFFF);
    queue_frame(OpBin, 4'hF, 0, LenShort, 32'h0000_0000);
    queue_frame(OpClose, 4'h8, 0, LenShort, $urandom);
    queue_frame(4'h9, 4'h0, 0, LenShort, $urandom);

    // random well-formed frames, control and reserved opcodes mixed in
    while (rx_stream_q.size() < RandomBytes) begin
      pick = $urandom_range(99);
      if (pick < 40) op = OpText;
      else if (pick < 70) op = OpBin;
      else if (pick < 78) op = OpClose;
      else op = 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 6) begin
        form = LenExt16;
        len  = $urandom_range(300);
      end else if (pick < 10) begin
        form = LenExt64;
        len  = $urandom_range(150);
      end else if (pick < 16) begin
        form = LenShort;
        len  = $urandom_range(125);
      end else begin
        form = LenShort;
        len  = $urandom_range(12);
      end
      queue_frame(op, 4'($urandom_range(15)), len, form, $urandom);
    end

    // unmasked frame halts the parser, the trailing bytes must be dropped
    stream_byte({4'h8, OpText});
    stream_byte(8'h05);
    stream_byte({4'h8, OpText});
    stream_byte(8'h80);
    stream_byte(8'hA5);
    total_items = rx_stream_q.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_stream_q.size() != 0 || rx_valid_i) @(posedge clk_i);
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // input driver, pauses once mid-run until all results are out
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_valid_i && rx_ready_o) begin
        deframe_byte(rx_byte_i);
        bytes_taken++;
        if (bytes_taken == total_items / 2) draining = 1'b1;
      end
      if (draining && deframed_q.size() == 0) draining = 1'b0;
      if (!rx_valid_i || rx_ready_o) begin
        if (rx_stream_q.size() != 0 && !draining &&
            (hold_left != 0 ||
             $urandom_range(99) >= (idle_stage == 0 ? 25 : idle_stage == 1 ? 53 : 0))) begin
          rx_valid_i <= 1'b1;
          rx_byte_i  <= rx_stream_q.pop_front();
        end else begin
          rx_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver backpressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tx_valid_o && tx_ready_i) begin
        if (deframed_q.size() == 0) begin
          $error("unexpected item: kind %0d data %02h opcode %0h last %0b",
                 kind_o, data_byte_o, frame_opcode_o, last_o);
          fail_count++;
        end else begin
          want = deframed_q.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind_o);
            fail_count++;
          end
          if (data_byte_o !== want.data) begin
            $error("data_byte: expected %02h, actual %02h", want.data, data_byte_o);
            fail_count++;
          end
          if (frame_opcode_o !== want.opcode) begin
            $error("frame_opcode: expected %0h, actual %0h", want.opcode, frame_opcode_o);
            fail_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last_o);
            fail_count++;
          end
        end
      end
      // one long hold-off so the block fills and stalls its input
      if (!hold_done && bytes_taken >= total_items / 6) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        tx_ready_i <= 1'b0;
      end else begin
        tx_ready_i <= $urandom_range(99) >=
                      (idle_stage == 0 ? 53 : idle_stage == 1 ? 25 : 0);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_valid_i && rx_ready_o) || (tx_valid_o && tx_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule
